[src/pms_pkg.sv]
// pms_pkg: shared types and constants of the proximity mode supervisor
// no dependencies
`default_nettype none

package pms_pkg;

    localparam logic [7:0] DELTA_SAT  = 8'h7F;
    localparam logic [7:0] DRIFT_MAX  = 8'h3F;
    localparam logic [7:0] SETTLE_MIN = 8'h50;
    localparam logic [7:0] DELTA_LOW  = 8'h00;
    localparam logic [7:0] DELTA_HIGH = 8'hFF;
    localparam logic [7:0] COUNT_MAX  = 8'hFF;
    localparam logic [7:0] ST_CH2     = 8'h02;
    localparam logic [7:0] ST_CH6     = 8'h20;
    localparam logic [7:0] ST_BOTH    = 8'h22;

    localparam logic [1:0] REG_SENSOR_ENABLE = 2'd0;
    localparam logic [1:0] REG_ACCUM_LIMIT   = 2'd1;
    localparam logic [1:0] REG_LOW_DELTA_CH2 = 2'd2;
    localparam logic [1:0] REG_LOW_DELTA_CH6 = 2'd3;

    localparam logic       CMD_SAMPLE = 1'b0;
    localparam logic       CMD_CHECK  = 1'b1;

    typedef struct packed {
        logic       sensor_enable;
        logic [7:0] accum_limit;
        logic [5:0] low_delta_ch2;
        logic [5:0] low_delta_ch6;
    } t_cfg;

    typedef struct packed {
        logic       wood_mode;
        logic [7:0] overflow_pattern;
        logic [7:0] drift_count_ch2;
        logic [7:0] drift_count_ch6;
        logic       presence;
    } t_state;

    typedef struct packed {
        logic object_present;
        logic high_sens_mode;
        logic enter_high_sens;
        logic leave_high_sens;
        logic force_recal;
        logic reevaluate;
    } t_result;

endpackage

`default_nettype wire

[src/pms_cfg_regs.sv]
// pms_cfg_regs: apb-style configuration registers
// depends on pms_pkg
`default_nettype none

module pms_cfg_regs (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output pms_pkg::t_cfg     o_cfg
);
    import pms_pkg::*;

    t_cfg       r_cfg;
    logic       w_write;
    logic [1:0] w_index;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite;
    assign w_index = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensor_enable <= 1'b1;
            r_cfg.accum_limit   <= 8'd10;
            r_cfg.low_delta_ch2 <= 6'd8;
            r_cfg.low_delta_ch6 <= 6'd10;
        end else if (w_write) begin
            unique case (w_index)
                REG_SENSOR_ENABLE: r_cfg.sensor_enable <= pwdata[0];
                REG_ACCUM_LIMIT:   r_cfg.accum_limit   <= pwdata[7:0];
                REG_LOW_DELTA_CH2: r_cfg.low_delta_ch2 <= pwdata[5:0];
                REG_LOW_DELTA_CH6: r_cfg.low_delta_ch6 <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = 32'd0;
        unique case (w_index)
            REG_SENSOR_ENABLE: prdata = {31'd0, r_cfg.sensor_enable};
            REG_ACCUM_LIMIT:   prdata = {24'd0, r_cfg.accum_limit};
            REG_LOW_DELTA_CH2: prdata = {26'd0, r_cfg.low_delta_ch2};
            REG_LOW_DELTA_CH6: prdata = {26'd0, r_cfg.low_delta_ch6};
            default:           prdata = 32'd0;
        endcase
    end

    a_write_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_write && w_index == REG_SENSOR_ENABLE) |=> (r_cfg.sensor_enable == $past(pwdata[0])))
        else $error("enable register write lost");
    a_write_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_write && w_index == REG_ACCUM_LIMIT) |=> (r_cfg.accum_limit == $past(pwdata[7:0])))
        else $error("limit register write lost");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !w_write |=> $stable(r_cfg))
        else $error("configuration changed without a write");

endmodule

`default_nettype wire

[src/pms_eval.sv]
// pms_eval: next-state and result logic for one sensor reading
// depends on pms_pkg
`default_nettype none

module pms_eval (
    input  wire pms_pkg::t_cfg    i_cfg,
    input  wire pms_pkg::t_state  i_state,
    input  wire logic         i_command,
    input  wire logic [7:0]   i_input_status,
    input  wire logic [7:0]   i_delta_ch2,
    input  wire logic [7:0]   i_delta_ch6,
    output pms_pkg::t_state   o_state,
    output pms_pkg::t_result  o_result
);
    import pms_pkg::*;

    logic       w_is2, w_is6, w_isb;
    logic       w_ovf;
    logic       w_inc2, w_inc6;
    logic [7:0] w_cnt2, w_cnt6;
    logic       w_recal;
    logic       w_set2, w_set6;
    logic       w_back;
    logic       w_pat2, w_pat6, w_patb;

    assign w_is2 = (i_input_status == ST_CH2);
    assign w_is6 = (i_input_status == ST_CH6);
    assign w_isb = (i_input_status == ST_BOTH);

    assign w_ovf = (w_is2 && i_delta_ch2 == DELTA_SAT)
                || (w_is6 && i_delta_ch6 == DELTA_SAT)
                || (w_isb && (i_delta_ch2 == DELTA_SAT || i_delta_ch6 == DELTA_SAT));

    assign w_inc2 = (i_delta_ch2 >= {2'b00, i_cfg.low_delta_ch2}) && (i_delta_ch2 <= DRIFT_MAX);
    assign w_inc6 = (i_delta_ch6 >= {2'b00, i_cfg.low_delta_ch6}) && (i_delta_ch6 <= DRIFT_MAX);

    assign w_cnt2 = (w_inc2 && i_state.drift_count_ch2 != COUNT_MAX)
                  ? i_state.drift_count_ch2 + 8'd1 : i_state.drift_count_ch2;
    assign w_cnt6 = (w_inc6 && i_state.drift_count_ch6 != COUNT_MAX)
                  ? i_state.drift_count_ch6 + 8'd1 : i_state.drift_count_ch6;

    assign w_recal = (w_cnt2 >= i_cfg.accum_limit) || (w_cnt6 >= i_cfg.accum_limit);

    assign w_set2 = (i_delta_ch2 > SETTLE_MIN) && (i_delta_ch2 <= DELTA_SAT);
    assign w_set6 = (i_delta_ch6 > SETTLE_MIN) && (i_delta_ch6 <= DELTA_SAT);

    assign w_pat2 = (i_state.overflow_pattern == ST_CH2);
    assign w_pat6 = (i_state.overflow_pattern == ST_CH6);
    assign w_patb = (i_state.overflow_pattern == ST_BOTH);

    assign w_back = ((i_delta_ch2 == DELTA_LOW || i_delta_ch2 == DELTA_HIGH)
                  && (i_delta_ch6 == DELTA_LOW || i_delta_ch6 == DELTA_HIGH))
                 || (w_pat2 && w_set2)
                 || (w_pat6 && w_set6)
                 || (w_patb && (w_set2 || w_set6));

    always_comb begin
        o_state                  = i_state;
        o_result.enter_high_sens = 1'b0;
        o_result.leave_high_sens = 1'b0;
        o_result.force_recal     = 1'b0;
        o_result.reevaluate      = 1'b0;
        if (i_cfg.sensor_enable) begin
            if (i_command == CMD_SAMPLE) begin
                if (!i_state.wood_mode) begin
                    o_state.presence = w_is2 || w_is6 || w_isb;
                    if (w_ovf) begin
                        o_result.enter_high_sens = 1'b1;
                        o_state.wood_mode        = 1'b1;
                        o_state.overflow_pattern = i_input_status;
                        o_state.drift_count_ch2  = 8'd0;
                        o_state.drift_count_ch6  = 8'd0;
                    end else if (w_recal) begin
                        o_result.force_recal     = 1'b1;
                        o_state.drift_count_ch2  = 8'd0;
                        o_state.drift_count_ch6  = 8'd0;
                    end else begin
                        o_state.drift_count_ch2  = w_cnt2;
                        o_state.drift_count_ch6  = w_cnt6;
                    end
                end
            end else if (i_state.wood_mode && w_back) begin
                o_result.leave_high_sens = 1'b1;
                o_result.reevaluate      = 1'b1;
                o_state.wood_mode        = 1'b0;
            end
        end
        o_result.object_present = o_state.presence;
        o_result.high_sens_mode = o_state.wood_mode;
    end

endmodule

`default_nettype wire

[src/proximity_mode_supervisor_core.sv]
// proximity_mode_supervisor_core: top level, input register, state and result register
// depends on pms_pkg, pms_cfg_regs, pms_eval
//
// channel   direction  handshake                 payload
// input     in         i_in_valid / o_in_stall   i_command, i_input_status, i_delta_ch2/6
// output    out        o_out_valid / i_out_stall o_object_present .. o_reevaluate
// config    in         psel/penable/pwrite       paddr, pwdata, prdata, pready
//
// one transaction per cycle sustained while the output is not stalled
// the input register feeds the decision logic, which updates state and the result register
// the input register takes one more transaction while a finished result waits under stall
// o_in_stall rises only when both registers are full and the output is stalled
// synchronous active-low reset restores the register defaults, clears the mode state and the valid flags
`default_nettype none

module proximity_mode_supervisor_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire logic         i_command,
    input  wire logic [7:0]   i_input_status,
    input  wire logic [7:0]   i_delta_ch2,
    input  wire logic [7:0]   i_delta_ch6,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output logic              o_object_present,
    output logic              o_high_sens_mode,
    output logic              o_enter_high_sens,
    output logic              o_leave_high_sens,
    output logic              o_force_recal,
    output logic              o_reevaluate
);
    import pms_pkg::*;

    t_cfg       w_cfg;
    t_state     r_state, n_state;
    t_result    r_result, n_result;
    logic       r_in_valid;
    logic       r_command;
    logic [7:0] r_input_status;
    logic [7:0] r_delta_ch2;
    logic [7:0] r_delta_ch6;
    logic       r_out_valid;
    logic       w_accept;
    logic       w_advance;

    pms_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pms_eval u_eval (
        .i_cfg          (w_cfg),
        .i_state        (r_state),
        .i_command      (r_command),
        .i_input_status (r_input_status),
        .i_delta_ch2    (r_delta_ch2),
        .i_delta_ch6    (r_delta_ch6),
        .o_state        (n_state),
        .o_result       (n_result)
    );

    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_command      <= i_command;
            r_input_status <= i_input_status;
            r_delta_ch2    <= i_delta_ch2;
            r_delta_ch6    <= i_delta_ch6;
        end
        if (w_advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_object_present  = r_result.object_present;
    assign o_high_sens_mode  = r_result.high_sens_mode;
    assign o_enter_high_sens = r_result.enter_high_sens;
    assign o_leave_high_sens = r_result.leave_high_sens;
    assign o_force_recal     = r_result.force_recal;
    assign o_reevaluate      = r_result.reevaluate;

    a_enter_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.enter_high_sens) |-> r_result.high_sens_mode)
        else $error("enter request without high-sensitivity mode");
    a_leave_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.leave_high_sens)
            |-> (!r_result.high_sens_mode && r_result.reevaluate))
        else $error("leave request inconsistent");
    a_recal_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.force_recal)
            |-> (!r_result.high_sens_mode && !r_result.enter_high_sens))
        else $error("recalibration outside normal mode");
    a_state_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> (r_state.wood_mode == r_result.high_sens_mode
                       && r_state.presence == r_result.object_present))
        else $error("result does not match stored state");

endmodule

`default_nettype wire

[dv/tb_top.sv]
// tb_top: self-checking testbench of proximity_mode_supervisor_core
// holds a scoreboard class that predicts each result, plus tasks for the input and apb ports
// depends on pms_pkg and the rtl under src

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pms_pkg::*;

    class mode_scoreboard;
        t_cfg        cfg = '{1'b1, 8'd10, 6'd8, 6'd10};
        t_state      st = '0;
        t_result     pending_results[$];
        int unsigned errors = 0;
        int unsigned readings = 0;
        int unsigned checked = 0;
        int unsigned entries = 0;
        int unsigned exits = 0;
        int unsigned recals = 0;
        int unsigned ignored = 0;

        function void apply_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_SENSOR_ENABLE: cfg.sensor_enable = value[0];
                REG_ACCUM_LIMIT:   cfg.accum_limit = value[7:0];
                REG_LOW_DELTA_CH2: cfg.low_delta_ch2 = value[5:0];
                REG_LOW_DELTA_CH6: cfg.low_delta_ch6 = value[5:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] bump(logic [7:0] v);
            return (v == COUNT_MAX) ? v : v + 8'd1;
        endfunction

        function logic settled(logic [7:0] d);
            return d > SETTLE_MIN && d <= DELTA_SAT;
        endfunction

        function logic stuck(logic [7:0] d);
            return d == DELTA_LOW || d == DELTA_HIGH;
        endfunction

        function void record_reading(logic cmd, logic [7:0] status, logic [7:0] d2,
                                     logic [7:0] d6);
            t_result want;
            logic    ovf;
            logic    back;
            want = '0;
            readings++;
            if (!cfg.sensor_enable) begin
                ignored++;
            end else if (cmd == CMD_SAMPLE) begin
                if (!st.wood_mode) begin
                    st.presence = (status == ST_CH2) || (status == ST_CH6) || (status == ST_BOTH);
                    ovf = (status == ST_CH2 && d2 == DELTA_SAT)
                       || (status == ST_CH6 && d6 == DELTA_SAT)
                       || (status == ST_BOTH && (d2 == DELTA_SAT || d6 == DELTA_SAT));
                    if (ovf) begin
                        want.enter_high_sens = 1'b1;
                        st.wood_mode = 1'b1;
                        st.overflow_pattern = status;
                        st.drift_count_ch2 = '0;
                        st.drift_count_ch6 = '0;
                        entries++;
                    end else begin
                        if (d2 >= {2'b00, cfg.low_delta_ch2} && d2 <= DRIFT_MAX)
                            st.drift_count_ch2 = bump(st.drift_count_ch2);
                        if (d6 >= {2'b00, cfg.low_delta_ch6} && d6 <= DRIFT_MAX)
                            st.drift_count_ch6 = bump(st.drift_count_ch6);
                        if (st.drift_count_ch2 >= cfg.accum_limit ||
                            st.drift_count_ch6 >= cfg.accum_limit) begin
                            want.force_recal = 1'b1;
                            st.drift_count_ch2 = '0;
                            st.drift_count_ch6 = '0;
                            recals++;
                        end
                    end
                end
            end else if (st.wood_mode) begin
                back = (stuck(d2) && stuck(d6))
                    || (st.overflow_pattern == ST_CH2 && settled(d2))
                    || (st.overflow_pattern == ST_CH6 && settled(d6))
                    || (st.overflow_pattern == ST_BOTH && (settled(d2) || settled(d6)));
                if (back) begin
                    want.leave_high_sens = 1'b1;
                    want.reevaluate = 1'b1;
                    st.wood_mode = 1'b0;
                    exits++;
                end
            end
            want.object_present = st.presence;
            want.high_sens_mode = st.wood_mode;
            pending_results.push_back(want);
        endfunction

        function void compare_field(string name, logic want, logic got);
            if (got !== want) begin
                $display("%0t ns: %s mismatch, expected %0b, got %0b", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got %b", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            compare_field("object_present", want.object_present, got.object_present);
            compare_field("high_sens_mode", want.high_sens_mode, got.high_sens_mode);
            compare_field("enter_high_sens", want.enter_high_sens, got.enter_high_sens);
            compare_field("leave_high_sens", want.leave_high_sens, got.leave_high_sens);
            compare_field("force_recal", want.force_recal, got.force_recal);
            compare_field("reevaluate", want.reevaluate, got.reevaluate);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_command = CMD_SAMPLE;
    logic [7:0]  i_input_status = '0;
    logic [7:0]  i_delta_ch2 = '0;
    logic [7:0]  i_delta_ch6 = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_object_present;
    logic        o_high_sens_mode;
    logic        o_enter_high_sens;
    logic        o_leave_high_sens;
    logic        o_force_recal;
    logic        o_reevaluate;

    int unsigned src_idle_pct = 0;
    int unsigned dst_idle_pct = 0;

    mode_scoreboard sb = new;

    proximity_mode_supervisor_core uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_command(i_command),
        .i_input_status(i_input_status),
        .i_delta_ch2(i_delta_ch2),
        .i_delta_ch6(i_delta_ch6),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_object_present(o_object_present),
        .o_high_sens_mode(o_high_sens_mode),
        .o_enter_high_sens(o_enter_high_sens),
        .o_leave_high_sens(o_leave_high_sens),
        .o_force_recal(o_force_recal),
        .o_reevaluate(o_reevaluate)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_stall <= (dst_idle_pct != 0) && ($urandom_range(99) < dst_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result({o_object_present, o_high_sens_mode, o_enter_high_sens,
                             o_leave_high_sens, o_force_recal, o_reevaluate});
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_reading(input logic cmd, input logic [7:0] status,
                                input logic [7:0] d2, input logic [7:0] d6);
        while ((src_idle_pct != 0) && ($urandom_range(99) < src_idle_pct)) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_input_status <= status;
        i_delta_ch2 <= d2;
        i_delta_ch6 <= d6;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.record_reading(cmd, status, d2, d6);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.apply_register(idx, value);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic en, input logic [7:0] lim,
                                  input logic [5:0] low2, input logic [5:0] low6);
        drain_results();
        cfg_write(REG_SENSOR_ENABLE, {31'd0, en});
        cfg_write(REG_ACCUM_LIMIT, {24'd0, lim});
        cfg_write(REG_LOW_DELTA_CH2, {26'd0, low2});
        cfg_write(REG_LOW_DELTA_CH6, {26'd0, low6});
    endtask

    function automatic logic [7:0] pick_delta();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return DELTA_SAT;
        if (r < 50) return 8'($urandom_range(DRIFT_MAX));
        if (r < 65) return 8'($urandom_range(DELTA_SAT, SETTLE_MIN));
        if (r < 80) return ($urandom_range(1) != 0) ? DELTA_HIGH : DELTA_LOW;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_status();
        if ($urandom_range(99) >= 70) return 8'($urandom);
        case ($urandom_range(2))
            0: return ST_CH2;
            1: return ST_CH6;
            default: return ST_BOTH;
        endcase
    endfunction

    task automatic send_random_reading();
        logic cmd;
        if (sb.st.wood_mode)
            cmd = ($urandom_range(99) < 75) ? CMD_CHECK : CMD_SAMPLE;
        else
            cmd = ($urandom_range(99) < 75) ? CMD_SAMPLE : CMD_CHECK;
        send_reading(cmd, pick_status(), pick_delta(), pick_delta());
    endtask

    task automatic run_directed();
        // overflow on channel two, then ignored sample, unsettled and settled checks
        send_reading(CMD_SAMPLE, ST_CH2, DELTA_SAT, DELTA_LOW);
        send_reading(CMD_SAMPLE, ST_BOTH, DELTA_SAT, DELTA_SAT);
        send_reading(CMD_CHECK, ST_CH2, 8'h30, 8'h30);
        send_reading(CMD_CHECK, ST_CH2, 8'h51, DELTA_LOW);
        send_reading(CMD_CHECK, ST_CH2, DELTA_LOW, DELTA_LOW);
        // channel six overflow, left through stuck deltas
        send_reading(CMD_SAMPLE, ST_CH6, DELTA_LOW, DELTA_SAT);
        send_reading(CMD_CHECK, ST_CH6, 8'h51, SETTLE_MIN);
        send_reading(CMD_CHECK, ST_CH6, DELTA_LOW, DELTA_HIGH);
        // both channels
        send_reading(CMD_SAMPLE, ST_BOTH, 8'h10, DELTA_SAT);
        send_reading(CMD_CHECK, ST_BOTH, SETTLE_MIN, DELTA_SAT);
        send_reading(CMD_SAMPLE, ST_BOTH, DELTA_SAT, DELTA_LOW);
        send_reading(CMD_CHECK, ST_BOTH, 8'h80, 8'h01);
        send_reading(CMD_CHECK, ST_BOTH, DELTA_HIGH, DELTA_HIGH);
        // malformed status bytes and drift counting
        send_reading(CMD_SAMPLE, 8'h03, DELTA_SAT, DELTA_SAT);
        send_reading(CMD_SAMPLE, 8'hFF, DELTA_HIGH, DELTA_HIGH);
        send_reading(CMD_SAMPLE, 8'h00, DRIFT_MAX, DRIFT_MAX);
        send_reading(CMD_SAMPLE, ST_CH2, DELTA_LOW, 8'h09);
        send_reading(CMD_SAMPLE, ST_CH6, 8'h08, 8'h0A);
        apply_settings(1'b1, 8'd2, 6'd8, 6'd10);
        send_reading(CMD_SAMPLE, ST_BOTH, 8'h40, DELTA_LOW);
        // zero limit recalibrates on every non-overflow sample
        apply_settings(1'b1, 8'd0, 6'd8, 6'd10);
        send_reading(CMD_SAMPLE, ST_CH2, DELTA_LOW, DELTA_LOW);
        // sensor disabled, state holds
        apply_settings(1'b0, 8'd0, 6'd8, 6'd10);
        send_reading(CMD_SAMPLE, ST_CH2, DELTA_SAT, DELTA_LOW);
        send_reading(CMD_CHECK, ST_CH2, DELTA_LOW, DELTA_LOW);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();

        for (int regime = 0; regime < 3; regime++) begin
            case (regime)
                0: begin src_idle_pct = 11; dst_idle_pct = 55; end
                1: begin src_idle_pct = 55; dst_idle_pct = 11; end
                default: begin src_idle_pct = 0; dst_idle_pct = 0; end
            endcase
            for (int p = 0; p < 6; p++) begin
                case (p)
                    0: apply_settings(1'b1, 8'd10, 6'd8, 6'd10);
                    1: apply_settings(1'b1, 8'd255, 6'd0, 6'd0);
                    2: apply_settings(1'b1, 8'd1, 6'd63, 6'd63);
                    3: apply_settings(1'b0, 8'd5, 6'd20, 6'd30);
                    4: apply_settings(1'b1, 8'd0, 6'd32, 6'd5);
                    default: apply_settings(1'b1, 8'($urandom_range(255, 1)),
                                            6'($urandom), 6'($urandom));
                endcase
                repeat (65) begin
                    if ($urandom_range(99) == 0) drain_results();
                    send_random_reading();
                end
            end
        end

        drain_results();
        repeat (6) @(negedge i_clk);
        $display("tb_top: %0d readings accepted, %0d results checked, %0d ignored while disabled",
                 sb.readings, sb.checked, sb.ignored);
        $display("tb_top: %0d high-sensitivity entries, %0d exits, %0d recalibrations",
                 sb.entries, sb.exits, sb.recals);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial begin
        #(6_000_000);
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
